### src/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the truecolor pixel packer modules.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int AddrW = 26;

  typedef enum logic [3:0] {
    CFG_RED_MASK        = 4'd0,
    CFG_GREEN_MASK      = 4'd1,
    CFG_BLUE_MASK       = 4'd2,
    CFG_PIXEL_SIZE_MODE = 4'd3,
    CFG_MSB_FIRST       = 4'd4,
    CFG_IMAGE_WIDTH     = 4'd5,
    CFG_IMAGE_HEIGHT    = 4'd6,
    CFG_LINE_BYTES      = 4'd7
  } cfg_idx_e;

  localparam logic [31:0] RedMaskRst   = 32'h00FF_0000;
  localparam logic [31:0] GreenMaskRst = 32'h0000_FF00;
  localparam logic [31:0] BlueMaskRst  = 32'h0000_00FF;
  localparam logic [1:0]  SizeModeRst  = 2'd3;
  localparam logic        MsbFirstRst  = 1'b0;
  localparam logic [12:0] WidthRst     = 13'd640;
  localparam logic [12:0] HeightRst    = 13'd480;
  localparam logic [14:0] LineBytesRst = 15'd2560;

  typedef struct packed {
    logic [31:0] red_sel;
    logic [31:0] green_sel;
    logic [31:0] blue_sel;
    logic [1:0]  pixel_size_mode;
    logic        msb_first;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [14:0] line_bytes;
  } cfg_t;

  // one packed pixel waiting for serialization
  typedef struct packed {
    logic [31:0]      word;
    logic [AddrW-1:0] addr;
    logic [1:0]       last_idx;
    logic             msb_first;
    logic             frame_end;
  } pix_t;

  // place an 8-bit component under its mask: left shift = top set bit - 7
  function automatic logic [31:0] place(input logic [7:0] c, input logic [31:0] mask);
    logic       found;
    logic [4:0] idx;
    logic [31:0] v;
    found = 1'b0;
    idx   = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mask[i]) begin
        found = 1'b1;
        idx   = 5'(i);
      end
    end
    if (!found) begin
      v = 32'd0;
    end else if (idx >= 5'd7) begin
      v = {24'd0, c} << (idx - 5'd7);
    end else begin
      v = {24'd0, c} >> (5'd7 - idx);
    end
    return v & mask;
  endfunction

endpackage

### src/rtp_front.sv
// ----------------------------------------------------------------------------
// rtp_front
// Accepts pixels, packs the word and walks column, row and address counters.
// ----------------------------------------------------------------------------
module rtp_front #(
  parameter int WIDTH_CAP      = 4096,
  parameter int HEIGHT_CAP     = 4096,
  parameter int MAX_LINE_BYTES = 16384
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtp_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rtp_pkg::pix_t       q_data_o
);

  localparam int CW = $clog2(WIDTH_CAP);
  localparam int RW = $clog2(HEIGHT_CAP);
  localparam int AW = rtp_pkg::AddrW;

  logic [CW-1:0] col_q, col_d, col_last;
  logic [RW-1:0] row_q, row_d, row_last;
  logic [AW-1:0] row_base_q, row_base_d, pix_addr_q, pix_addr_d;
  logic [AW-1:0] stride, nbytes;
  logic          row_end, frame_end;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    if (cfg_i.image_width == 13'd0) begin
      col_last = '0;
    end else if (32'(cfg_i.image_width) > 32'(WIDTH_CAP)) begin
      col_last = CW'(WIDTH_CAP - 1);
    end else begin
      col_last = CW'(cfg_i.image_width - 13'd1);
    end
    if (cfg_i.image_height == 13'd0) begin
      row_last = '0;
    end else if (32'(cfg_i.image_height) > 32'(HEIGHT_CAP)) begin
      row_last = RW'(HEIGHT_CAP - 1);
    end else begin
      row_last = RW'(cfg_i.image_height - 13'd1);
    end
    if (32'(cfg_i.line_bytes) > 32'(MAX_LINE_BYTES)) begin
      stride = AW'(MAX_LINE_BYTES);
    end else begin
      stride = AW'(cfg_i.line_bytes);
    end
  end

  assign nbytes    = AW'(cfg_i.pixel_size_mode) + AW'(1);
  assign row_end   = col_q >= col_last;
  assign frame_end = row_end && (row_q >= row_last);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    pix_addr_d = pix_addr_q;
    if (q_push_o) begin
      if (frame_end) begin
        col_d      = '0;
        row_d      = '0;
        row_base_d = '0;
        pix_addr_d = '0;
      end else if (row_end) begin
        col_d      = '0;
        row_d      = row_q + RW'(1);
        row_base_d = row_base_q + stride;
        pix_addr_d = row_base_q + stride;
      end else begin
        col_d      = col_q + CW'(1);
        pix_addr_d = pix_addr_q + nbytes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      pix_addr_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      pix_addr_q <= pix_addr_d;
    end
  end

  always_comb begin
    q_data_o.word      = rtp_pkg::place(red_i, cfg_i.red_sel)
                       | rtp_pkg::place(green_i, cfg_i.green_sel)
                       | rtp_pkg::place(blue_i, cfg_i.blue_sel);
    q_data_o.addr      = pix_addr_q;
    q_data_o.last_idx  = cfg_i.pixel_size_mode;
    q_data_o.msb_first = cfg_i.msb_first;
    q_data_o.frame_end = frame_end;
  end

endmodule

### src/rtp_queue.sv
// ----------------------------------------------------------------------------
// rtp_queue
// Two-entry queue of packed pixels between front and back.
// ----------------------------------------------------------------------------
module rtp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rtp_pkg::pix_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rtp_pkg::pix_t head_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  rtp_pkg::pix_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### src/rtp_back.sv
// ----------------------------------------------------------------------------
// rtp_back
// Serializes the queue head into bytes through a registered output stage.
// ----------------------------------------------------------------------------
module rtp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  rtp_pkg::pix_t               head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  byte_value_o,
  output logic [rtp_pkg::AddrW-1:0]   byte_address_o,
  output logic                        last_byte_of_pixel_o,
  output logic                        end_of_frame_o
);

  localparam int AW = rtp_pkg::AddrW;

  logic [1:0]    k_q, k_d, pos;
  logic          load, last;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    byte_q;
  logic [AW-1:0] addr_q;
  logic          last_q, eof_q;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last = k_q == head_i.last_idx;
  assign pos  = head_i.msb_first ? (head_i.last_idx - k_q) : k_q;
  assign pop_o = load && last;

  always_comb begin
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      k_d         = last ? 2'd0 : k_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.word[{pos, 3'b000} +: 8];
      addr_q <= head_i.addr + AW'(k_q);
      last_q <= last;
      eof_q  <= last && head_i.frame_end;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign byte_value_o         = byte_q;
  assign byte_address_o       = addr_q;
  assign last_byte_of_pixel_o = last_q;
  assign end_of_frame_o       = eof_q;

endmodule

### src/rgb_to_truecolor_pixel_packer.sv
// ----------------------------------------------------------------------------
// rgb_to_truecolor_pixel_packer
// Packs RGB888 pixels into truecolor frame-buffer bytes with addresses.
// ----------------------------------------------------------------------------
// Each accepted pixel produces pixel_size_mode+1 bytes, one per cycle on the
// byte output register while out_stall_i is low, so a pixel costs 1 to 4 bytes
// (4 at 32 bpp). The front packs the word and updates the counters in the
// cycle of acceptance; a two-entry queue lets input keep flowing while the
// back serializes bytes. The first byte of a pixel passes from its queue entry
// to the byte output register; output stalls reach in_stall_o once both
// queue entries are held.
module rgb_to_truecolor_pixel_packer #(
  parameter int WIDTH_CAP      = 4096,
  parameter int HEIGHT_CAP     = 4096,
  parameter int MAX_LINE_BYTES = 16384
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [3:0]                cfg_index_i,
  input  logic [31:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                byte_value_o,
  output logic [rtp_pkg::AddrW-1:0] byte_address_o,
  output logic                      last_byte_of_pixel_o,
  output logic                      end_of_frame_o
);

  rtp_pkg::cfg_t cfg_q;
  rtp_pkg::pix_t push_data, head;
  logic          push, full, pop, head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_sel         <= rtp_pkg::RedMaskRst;
      cfg_q.green_sel       <= rtp_pkg::GreenMaskRst;
      cfg_q.blue_sel        <= rtp_pkg::BlueMaskRst;
      cfg_q.pixel_size_mode <= rtp_pkg::SizeModeRst;
      cfg_q.msb_first       <= rtp_pkg::MsbFirstRst;
      cfg_q.image_width     <= rtp_pkg::WidthRst;
      cfg_q.image_height    <= rtp_pkg::HeightRst;
      cfg_q.line_bytes      <= rtp_pkg::LineBytesRst;
    end else if (cfg_we_i) begin
      case (rtp_pkg::cfg_idx_e'(cfg_index_i))
        rtp_pkg::CFG_RED_MASK:        cfg_q.red_sel         <= cfg_data_i;
        rtp_pkg::CFG_GREEN_MASK:      cfg_q.green_sel       <= cfg_data_i;
        rtp_pkg::CFG_BLUE_MASK:       cfg_q.blue_sel        <= cfg_data_i;
        rtp_pkg::CFG_PIXEL_SIZE_MODE: cfg_q.pixel_size_mode <= cfg_data_i[1:0];
        rtp_pkg::CFG_MSB_FIRST:       cfg_q.msb_first       <= cfg_data_i[0];
        rtp_pkg::CFG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data_i[12:0];
        rtp_pkg::CFG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data_i[12:0];
        rtp_pkg::CFG_LINE_BYTES:      cfg_q.line_bytes      <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  rtp_front #(
    .WIDTH_CAP      (WIDTH_CAP),
    .HEIGHT_CAP     (HEIGHT_CAP),
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  rtp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  rtp_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_valid_i         (head_valid),
    .head_i               (head),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .byte_value_o         (byte_value_o),
    .byte_address_o       (byte_address_o),
    .last_byte_of_pixel_o (last_byte_of_pixel_o),
    .end_of_frame_o       (end_of_frame_o)
  );

  // frame end is only flagged on a pixel's final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_frame_o |-> last_byte_of_pixel_o)
    else $error("end_of_frame without last_byte_of_pixel");

  // bytes of one pixel follow back to back at consecutive addresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_byte_of_pixel_o |=>
      out_valid_o && byte_address_o == rtp_pkg::AddrW'($past(byte_address_o) + 1'b1))
    else $error("pixel bytes not contiguous");

  // after a frame end the next item restarts at address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && end_of_frame_o |=> !out_valid_o || byte_address_o == '0)
    else $error("frame did not wrap to address zero");

endmodule
